[rtl/core/tcwc_pkg.sv]
package tcwc_pkg;

  // Congestion phase codes
  localparam logic [1:0] PH_OPEN     = 2'd0;
  localparam logic [1:0] PH_DISORDER = 2'd1;
  localparam logic [1:0] PH_RECOVERY = 2'd2;
  localparam logic [1:0] PH_FAST     = 2'd3;

  // 16.16 window constants
  localparam logic [31:0] ONE_SEG  = 32'h0001_0000;
  localparam logic [31:0] HALF_SEG = 32'h0000_8000;
  localparam logic [15:0] THRESHOLD_INIT = 16'd16;

  localparam logic [7:0] DUP_TRIGGER = 8'd3;
  localparam logic [7:0] DUP_MAX     = 8'd255;

  // Reciprocal divider: one quotient bit per cycle, 33 bits
  localparam int          RECIP_QW   = 33;
  localparam logic [5:0]  RECIP_LAST = 6'(RECIP_QW - 1);

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_DIV  = 5'b00100,
    S_ADD  = 5'b01000,
    S_OUT  = 5'b10000
  } seq_state_t;

endpackage

[rtl/core/tcp_congestion_window_control_core.sv]
// From accept to result valid the sequencer passes S_EVAL, then S_OUT when no
// 1/window term is needed; when it is, S_DIV runs the 33-step restoring divider
// for 2^32/window and S_ADD adds the term before S_OUT. One ACK at a time; the
// next ACK is taken while a finished result still waits in the output register.
// Reset (rst, synchronous): phase open, window one segment, threshold 16.
module tcp_congestion_window_control_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [tcwc_pkg::IN_DATA_W-1:0] s_axis_tdata,  // ack_number, send_next
  input  logic [0:0]  s_axis_tuser,                      // is_new_ack
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // retransmit, window_fixed, threshold, phase, zero pad
  output logic [tcwc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tcwc_pkg::*;

  seq_state_t state;

  logic        new_q;
  logic [31:0] ack_q;
  logic [31:0] snd_q;
  logic        retx_q;

  logic [1:0]  phase_reg;
  logic [31:0] window_reg;
  logic [15:0] threshold_reg;
  logic [7:0]  duplicate_count;
  logic        halving_done;
  logic [31:0] recover_seq;

  logic [1:0]  phase_next;
  logic [31:0] window_next;
  logic [15:0] threshold_next;
  logic [7:0]  dup_next;
  logic        halving_next;
  logic [31:0] recovery_next;
  logic        retx_next;
  logic        need_recip;

  logic [31:0] half_win;
  logic [31:0] half_again;
  logic [15:0] cut_thr;
  logic [32:0] seg_sum;
  logic [31:0] grown_seg;

  logic        recip_start;
  logic        recip_done;
  logic [32:0] recip_q;
  logic [33:0] recip_sum;

  function automatic logic [31:0] minus_half(input logic [31:0] w);
    minus_half = (w < HALF_SEG) ? 32'd0 : w - HALF_SEG;
  endfunction

  tcwc_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (recip_start),
    .divisor  (window_reg),
    .done     (recip_done),
    .quotient (recip_q)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign recip_start   = (state == S_EVAL) && need_recip && (window_reg != 32'd0);
  assign recip_sum     = {2'b00, window_reg} + {1'b0, recip_q};

  always_comb begin
    half_win   = minus_half(window_reg);
    cut_thr    = (window_reg[31:17] == 15'd0) ? 16'd1 : {1'b0, window_reg[31:17]};
    half_again = half_win - HALF_SEG;
    seg_sum    = {1'b0, window_reg} + {1'b0, ONE_SEG};
    grown_seg  = seg_sum[32] ? 32'hFFFF_FFFF : seg_sum[31:0];
  end

  // Decide the whole update except the 1/window addition
  always_comb begin
    phase_next     = phase_reg;
    window_next    = window_reg;
    threshold_next = threshold_reg;
    halving_next   = halving_done;
    recovery_next  = recover_seq;
    retx_next      = 1'b0;
    need_recip     = 1'b0;
    if (new_q) begin
      dup_next = 8'd0;
    end else begin
      dup_next = (duplicate_count != DUP_MAX) ? duplicate_count + 8'd1 : duplicate_count;
    end

    if (new_q && phase_reg != PH_FAST) begin
      phase_next = PH_OPEN;
      if (window_reg[31:16] < threshold_reg) begin
        window_next = grown_seg;
      end else begin
        need_recip = 1'b1;
      end
    end else if (!new_q && (phase_reg == PH_OPEN || phase_reg == PH_DISORDER)) begin
      phase_next = (phase_reg == PH_OPEN) ? PH_DISORDER : PH_RECOVERY;
      if (window_reg[31:16] < threshold_reg) begin
        window_next = grown_seg;
      end else begin
        need_recip = 1'b1;
      end
    end else if (!new_q && phase_reg == PH_RECOVERY) begin
      // fast retransmit on the third duplicate, then the first halving step
      if (dup_next == DUP_TRIGGER) begin
        threshold_next = cut_thr;
        recovery_next  = snd_q;
        retx_next      = 1'b1;
        phase_next     = PH_FAST;
        if (half_win > {cut_thr, 16'h0000}) begin
          window_next  = half_again;
          halving_next = 1'b0;
        end else begin
          window_next  = half_win;
          halving_next = 1'b1;
        end
      end
    end else begin
      // fast recovery: halving step, or 1/window growth once halved, on new or duplicate ACK
      if (halving_done) begin
        need_recip = 1'b1;
      end else if (window_reg > {threshold_reg, 16'h0000}) begin
        window_next = half_win;
      end else begin
        halving_next = 1'b1;
      end
      if (new_q) begin
        if (ack_q < recover_seq) begin
          retx_next = 1'b1;
        end else begin
          phase_next = PH_OPEN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      new_q <= s_axis_tuser[0];
      ack_q <= s_axis_tdata[31:0];
      snd_q <= s_axis_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase_reg       <= PH_OPEN;
      window_reg      <= ONE_SEG;
      threshold_reg   <= THRESHOLD_INIT;
      duplicate_count <= 8'd0;
      halving_done    <= 1'b0;
      recover_seq     <= 32'd0;
      retx_q          <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          phase_reg       <= phase_next;
          threshold_reg   <= threshold_next;
          duplicate_count <= dup_next;
          halving_done    <= halving_next;
          recover_seq     <= recovery_next;
          retx_q          <= retx_next;
          if (need_recip && window_reg == 32'd0) begin
            // zero window: reciprocal saturates
            window_reg <= 32'hFFFF_FFFF;
            state      <= S_OUT;
          end else if (need_recip) begin
            state <= S_DIV;
          end else begin
            window_reg <= window_next;
            state      <= S_OUT;
          end
        end
        S_DIV: begin
          if (recip_done) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          window_reg <= (recip_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : recip_sum[31:0];
          state      <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {5'd0, phase_reg, threshold_reg, window_reg, retx_q};
    end
  end

endmodule

[rtl/core/tcwc_recip.sv]
module tcwc_recip (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [32:0] quotient
);
  import tcwc_pkg::*;

  logic [31:0] divisor_q;
  logic [31:0] rem;
  logic [5:0]  count;
  logic        busy;

  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  // Dividend is 2^32: only the first step brings in a one
  always_comb begin
    shifted = {rem, (count == RECIP_LAST)};
    diff    = shifted - {1'b0, divisor_q};
    ge      = (shifted >= {1'b0, divisor_q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor_q <= divisor;
      rem       <= 32'd0;
      count     <= RECIP_LAST;
      quotient  <= 33'd0;
    end else if (busy) begin
      rem      <= ge ? diff[31:0] : shifted[31:0];
      quotient <= {quotient[31:0], ge};
      count    <= count - 6'd1;
    end
  end

endmodule

[tb/tcp_congestion_window_control_core_tb.sv]
module tcp_congestion_window_control_core_tb;
  import tcwc_pkg::*;

  localparam int RANDOM_ACKS = 1500;
  localparam int QUIET_TAIL  = 150;   // no idling once this few ACKs remain
  localparam int DRAIN_WAIT  = 40;    // longest accept-to-result latency plus margin
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic        is_new;
    logic [31:0] ack_no;
    logic [31:0] snd_nxt;
  } ack_beat_t;

  typedef struct packed {
    logic        retx;
    logic [31:0] cwnd;
    logic [15:0] ssthresh;
    logic [1:0]  cc_phase;
  } cc_update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic [IN_DATA_W-1:0]  in_data  = '0;
  logic [0:0]            in_user  = '0;
  logic                  out_ready = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  tcp_congestion_window_control_core uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(in_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (in_data),
    .s_axis_tuser (in_user),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(out_ready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  ack_beat_t  pending_acks[$];
  cc_update_t predicted_updates[$];
  ack_beat_t  ack_on_bus;
  int send_gap = 0;
  int recv_stall = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int new_acks_seen = 0, dup_acks_seen = 0, retx_seen = 0, fast_seen = 0;

  // congestion state mirror
  logic [1:0]  cc_phase    = PH_OPEN;
  logic [31:0] cc_window   = ONE_SEG;
  logic [15:0] cc_ssthresh = THRESHOLD_INIT;
  logic [7:0]  cc_dupacks  = '0;
  logic        cc_halved   = 1'b0;
  logic [31:0] cc_recover  = '0;

  function automatic logic [31:0] add_clamped(logic [31:0] a, logic [32:0] b);
    logic [33:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [32:0] inv_window(logic [31:0] w);
    logic [63:0] q;
    if (w == '0) return 33'h0_FFFF_FFFF;
    q = 64'h1_0000_0000 / {32'h0, w};
    return q[32:0];
  endfunction

  task automatic grow_cwnd();
    if (cc_window[31:16] < cc_ssthresh) cc_window = add_clamped(cc_window, {1'b0, ONE_SEG});
    else cc_window = add_clamped(cc_window, inv_window(cc_window));
  endtask

  task automatic halve_cwnd();
    cc_window = (cc_window < HALF_SEG) ? 32'h0 : cc_window - HALF_SEG;
  endtask

  // one ACK's worth of gradual halving, then 1/cwnd growth once the target is met
  task automatic recovery_step();
    if (cc_halved) cc_window = add_clamped(cc_window, inv_window(cc_window));
    else if (cc_window > {cc_ssthresh, 16'h0}) halve_cwnd();
    else cc_halved = 1'b1;
  endtask

  task automatic newreno_step(ack_beat_t b);
    cc_update_t u;
    logic [14:0] t;
    u.retx = 1'b0;
    if (b.is_new) begin
      cc_dupacks = '0;
      if (cc_phase == PH_FAST) begin
        recovery_step();
        if (b.ack_no < cc_recover) u.retx = 1'b1;
        else cc_phase = PH_OPEN;
      end else begin
        grow_cwnd();
        cc_phase = PH_OPEN;
      end
    end else begin
      if (cc_dupacks != DUP_MAX) cc_dupacks = cc_dupacks + 8'd1;
      if (cc_phase == PH_OPEN || cc_phase == PH_DISORDER) begin
        grow_cwnd();
        cc_phase = (cc_phase == PH_OPEN) ? PH_DISORDER : PH_RECOVERY;
      end else begin
        if (cc_phase == PH_RECOVERY && cc_dupacks == DUP_TRIGGER) begin
          t = cc_window[31:17];
          cc_ssthresh = (t == '0) ? 16'd1 : {1'b0, t};
          halve_cwnd();
          cc_halved  = 1'b0;
          cc_recover = b.snd_nxt;
          u.retx     = 1'b1;
          cc_phase   = PH_FAST;
        end
        if (cc_phase == PH_FAST) recovery_step();
      end
    end
    u.cwnd     = cc_window;
    u.ssthresh = cc_ssthresh;
    u.cc_phase = cc_phase;
    predicted_updates.push_back(u);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t: %s got 0x%h expected 0x%h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_update(logic [OUT_DATA_W-1:0] d);
    cc_update_t want;
    if (predicted_updates.size() == 0) begin
      report_mismatch("result with nothing pending, tdata", d[31:0], 32'h0);
      return;
    end
    want = predicted_updates.pop_front();
    if (d[0] !== want.retx)
      report_mismatch("retransmit", 32'(d[0]), 32'(want.retx));
    if (d[32:1] !== want.cwnd) report_mismatch("window", d[32:1], want.cwnd);
    if (d[48:33] !== want.ssthresh)
      report_mismatch("threshold", 32'(d[48:33]), 32'(want.ssthresh));
    if (d[50:49] !== want.cc_phase)
      report_mismatch("phase", 32'(d[50:49]), 32'(want.cc_phase));
    if (want.retx) retx_seen++;
    if (want.cc_phase == PH_FAST) fast_seen++;
  endtask

  task automatic queue_ack(logic is_new, logic [31:0] ack_no, logic [31:0] snd_nxt);
    ack_beat_t b;
    b.is_new  = is_new;
    b.ack_no  = ack_no;
    b.snd_nxt = snd_nxt;
    pending_acks.push_back(b);
  endtask

  // sender: hold each beat until taken, idle in random bursts
  always @(posedge clk) begin
    ack_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && s_axis_tready) begin
        newreno_step(ack_on_bus);
        if (ack_on_bus.is_new) new_acks_seen++;
        else dup_acks_seen++;
      end
      if (!in_valid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_acks.size() > 0) begin
          nxt = pending_acks.pop_front();
          ack_on_bus = nxt;
          in_data  <= {nxt.snd_nxt, nxt.ack_no};
          in_user  <= nxt.is_new;
          in_valid <= 1'b1;
          if (pending_acks.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result beat, stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && out_ready) check_update(m_axis_tdata);
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (pending_acks.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        recv_stall = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && s_axis_tready) || (m_axis_tvalid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int target, n, k;
    logic [31:0] rp;
    bit long_run_done;
    long_run_done = 0;

    // directed: slow start, all phase moves, partial ACKs, sequence extremes
    queue_ack(1'b1, 32'h0, 32'h0);
    queue_ack(1'b0, 32'hFFFF_FFFF, 32'h0);
    queue_ack(1'b0, 32'h0, 32'h0);
    queue_ack(1'b0, 32'h0, 32'hFFFF_FFFF);         // third duplicate: fast retransmit
    queue_ack(1'b0, 32'h0, 32'h0);
    queue_ack(1'b1, 32'h0, 32'h0);                 // partial ACK at the bottom
    queue_ack(1'b1, 32'hFFFF_FFFE, 32'h0);         // partial ACK just below the point
    queue_ack(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // full ACK ends recovery
    queue_ack(1'b0, 32'h1234_5678, 32'h0);
    queue_ack(1'b0, 32'h1234_5678, 32'h0);
    queue_ack(1'b1, 32'h1234_5679, 32'h0);         // new ACK while in recovery
    for (int i = 0; i < 3; i++) queue_ack(1'b0, 32'h0, 32'h0);
    queue_ack(1'b1, 32'h0, 32'h0);                 // ACK equal to the recovery point
    for (int i = 0; i < 10; i++) queue_ack(1'b1, 32'h5555_5555 << i, 32'hAAAA_AAAA >> i);

    target = pending_acks.size() + RANDOM_ACKS;
    while (pending_acks.size() < target) begin
      k = $urandom_range(0, 9);
      if (k < 2) begin
        n = $urandom_range(1, 6);
        repeat (n) queue_ack(1'($urandom_range(0, 1)), $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 7))
          0:       rp = 32'h0;
          1:       rp = 32'hFFFF_FFFF;
          default: rp = $urandom;
        endcase
        n = $urandom_range(1, 12);
        repeat (n) queue_ack(1'b1, $urandom, $urandom);
        if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 2);
        else n = $urandom_range(3, 8);
        // one long duplicate run to saturate the duplicate count
        if (!long_run_done && pending_acks.size() > target / 2) begin
          n = 270;
          long_run_done = 1;
        end
        repeat (n) queue_ack(1'b0, $urandom, rp);
        n = $urandom_range(0, 4);
        repeat (n) begin
          if (rp != 0) queue_ack(1'b1, $urandom_range(0, rp - 1), $urandom);
          if ($urandom_range(0, 3) == 0) queue_ack(1'b0, $urandom, $urandom);
        end
        queue_ack(1'b1, $urandom_range(rp, 32'hFFFF_FFFF), $urandom);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_acks.size() > 0 || in_valid || predicted_updates.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (predicted_updates.size() != 0)
      report_mismatch("results never delivered, count", 32'(predicted_updates.size()),
                      32'h0);

    $display("covered %0d new ACKs and %0d duplicate ACKs", new_acks_seen, dup_acks_seen);
    $display("%0d retransmit requests, %0d results in fast recovery", retx_seen, fast_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
